// ===== hdl/mva_pkg.sv =====
package mva_pkg;

    localparam int VOICE_IDX_W = 4;
    localparam int NOTE_W      = 7;
    localparam int VEL_W       = 7;
    localparam int CMD_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int COUNT_W     = 5;

    localparam logic [1:0] MODE_POLY_OMNI = 2'd0;
    localparam logic [1:0] MODE_MONO_OMNI = 2'd1;
    localparam logic [1:0] MODE_POLY_CHAN = 2'd2;
    localparam logic [1:0] MODE_MONO_RANGE = 2'd3;

    localparam logic OP_NOTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic scan_needed;
        logic scan_last;
    } t_dp_status;

endpackage

// ===== hdl/mva_ctrl.sv =====
module mva_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  mva_pkg::t_dp_status i_status,
    output mva_pkg::t_ctrl_cmd  o_cmd,
    output logic                busy
);
    import mva_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.scan_needed ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/mva_datapath.sv =====
module mva_datapath #(
    parameter int MAX_VOICES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mva_pkg::t_ctrl_cmd                 i_cmd,
    output mva_pkg::t_dp_status                o_status_bits,
    input  logic                               i_cfg_write,
    input  logic [mva_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mva_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_opcode,
    input  logic [mva_pkg::CMD_W-1:0]          i_command,
    input  logic [mva_pkg::NOTE_W-1:0]         i_note_number,
    input  logic [mva_pkg::VEL_W-1:0]          i_note_velocity,
    output logic                               o_done,
    output logic                               o_status,
    output logic                               o_action_valid,
    output logic [mva_pkg::VOICE_IDX_W-1:0]    o_voice_index,
    output logic [mva_pkg::NOTE_W-1:0]         o_action_note,
    output logic [mva_pkg::VEL_W-1:0]          o_action_velocity,
    output logic                               o_action_on
);
    import mva_pkg::*;

    localparam int IW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam logic [COUNT_W-1:0] MAXV = COUNT_W'(MAX_VOICES);

    // config
    logic [1:0]         r_mode;
    logic [3:0]         r_base;
    logic [COUNT_W-1:0] r_count;

    // voice table; note is only meaningful while the voice is active
    logic [MAX_VOICES-1:0] r_active;
    logic [NOTE_W-1:0]     r_vnote [MAX_VOICES];

    // latched message
    logic              r_clear;
    logic              r_bad;
    logic              r_poly;
    logic              r_is_on;
    logic              r_mono_ok;
    logic [NOTE_W-1:0] r_note;
    logic [VEL_W-1:0]  r_vel;

    // scan
    logic [IW-1:0] r_idx;
    logic          r_found_on;
    logic [IW-1:0] r_on_idx;
    logic          r_found_free;
    logic [IW-1:0] r_free_idx;

    // result
    logic                   r_done;
    logic                   r_res_status;
    logic                   r_res_valid;
    logic [VOICE_IDX_W-1:0] r_res_idx;
    logic [NOTE_W-1:0]      r_res_note;
    logic [VEL_W-1:0]       r_res_vel;
    logic                   r_res_on;

    logic [COUNT_W-1:0] n_used;
    logic [3:0]         in_kind;
    logic [3:0]         in_ch;
    logic               in_on;
    logic               in_off;
    logic               in_poly;
    logic               in_accept;
    logic [3:0]         in_mono;
    logic [COUNT_W-1:0] base_plus_n;
    logic               rd_active;
    logic [NOTE_W-1:0]  rd_note;
    logic               hit;
    logic [IW-1:0]      widx;

    always_comb begin
        if (r_count == '0) begin
            n_used = COUNT_W'(1);
        end else if (r_count > MAXV) begin
            n_used = MAXV;
        end else begin
            n_used = r_count;
        end
    end

    assign in_kind     = i_command[7:4];
    assign in_ch       = i_command[3:0];
    assign in_on       = (in_kind == KIND_NOTE_ON) && (i_note_velocity != '0);
    assign in_off      = (in_kind == KIND_NOTE_OFF) ||
                         ((in_kind == KIND_NOTE_ON) && (i_note_velocity == '0));
    assign in_poly     = (r_mode == MODE_POLY_OMNI) || (r_mode == MODE_POLY_CHAN);
    assign base_plus_n = COUNT_W'(r_base) + n_used;

    always_comb begin
        case (r_mode)
            MODE_POLY_CHAN:  in_accept = (in_ch == r_base);
            MODE_MONO_RANGE: in_accept = (in_ch >= r_base) &&
                                         (COUNT_W'(in_ch) < base_plus_n);
            default:         in_accept = 1'b1;
        endcase
    end

    assign in_mono = (r_mode == MODE_MONO_RANGE) ? (in_ch - r_base) : 4'd0;

    assign o_status_bits.scan_needed = (i_opcode == OP_NOTE) && in_poly && in_accept &&
                                       (in_on || in_off);
    assign o_status_bits.scan_last   = (COUNT_W'(r_idx) == (n_used - COUNT_W'(1)));

    // single read port, addressed by the scan pointer
    assign rd_active = r_active[r_idx];
    assign rd_note   = r_vnote[r_idx];

    always_comb begin
        hit  = 1'b0;
        widx = r_idx;
        if (r_poly) begin
            if (r_is_on) begin
                hit  = !r_found_on && r_found_free;
                widx = r_free_idx;
            end else begin
                hit  = r_found_on;
                widx = r_on_idx;
            end
        end else if (r_mono_ok) begin
            if (r_is_on) begin
                hit = !rd_active || (rd_note < r_note);
            end else begin
                hit = rd_active && (rd_note == r_note);
            end
        end
        if (r_clear || r_bad) begin
            hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_POLY_OMNI;
            r_base   <= '0;
            r_count  <= COUNT_W'(16);
            r_active <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cfg_write) begin
                case (i_cfg_index)
                    CFG_MODE: begin
                        r_mode   <= i_cfg_data[1:0];
                        r_active <= '0;
                    end
                    CFG_BASE:  r_base  <= i_cfg_data[3:0];
                    CFG_COUNT: r_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                if (r_clear) begin
                    r_active <= '0;
                end else if (hit) begin
                    r_active[widx] <= r_is_on;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && hit) begin
            r_vnote[widx] <= r_note;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_clear      <= (i_opcode == OP_CLEAR);
            r_bad        <= (i_opcode == OP_NOTE) && !(in_accept && (in_on || in_off));
            r_poly       <= in_poly;
            r_is_on      <= in_on;
            r_mono_ok    <= (COUNT_W'(in_mono) < n_used);
            r_note       <= i_note_number;
            r_vel        <= i_note_velocity;
            r_idx        <= in_poly ? '0 : IW'(in_mono);
            r_found_on   <= 1'b0;
            r_found_free <= 1'b0;
        end else if (i_cmd.step) begin
            if (rd_active && (rd_note == r_note) && !r_found_on) begin
                r_found_on <= 1'b1;
                r_on_idx   <= r_idx;
            end
            if (!rd_active && !r_found_free) begin
                r_found_free <= 1'b1;
                r_free_idx   <= r_idx;
            end
            r_idx <= IW'(r_idx + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res_status <= r_bad ? STATUS_BAD : STATUS_OK;
            r_res_valid  <= hit;
            r_res_idx    <= hit ? VOICE_IDX_W'(widx) : '0;
            r_res_note   <= hit ? r_note : '0;
            r_res_vel    <= hit ? r_vel : '0;
            r_res_on     <= hit && r_is_on;
        end
    end

    assign o_done            = r_done;
    assign o_status          = r_res_status;
    assign o_action_valid    = r_res_valid;
    assign o_voice_index     = r_res_idx;
    assign o_action_note     = r_res_note;
    assign o_action_velocity = r_res_vel;
    assign o_action_on       = r_res_on;

endmodule

// ===== hdl/midi_voice_allocator.sv =====
// channel   direction  handshake                 payload
// command   in         start & !busy             i_opcode, i_command, i_note_number,
//                                                i_note_velocity
// result    out        o_done (one-cycle strobe) o_status, o_action_valid, o_voice_index,
//                                                o_action_note, o_action_velocity, o_action_on
// config    in         i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//
// Accepted poly note messages scan the voice table one entry per cycle, over the n voices in use.
// Mono messages, clears and rejected messages do not scan the table.
// The result strobe comes the cycle after the finish state; busy is already low then.
// Reset is synchronous, active low: table empty, mode 0, base channel 0, 16 voices.
// Results cannot be held off by the receiver; o_done lasts exactly one cycle.
module midi_voice_allocator #(
    parameter int MAX_VOICES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_opcode,
    input  logic [mva_pkg::CMD_W-1:0]       i_command,
    input  logic [mva_pkg::NOTE_W-1:0]      i_note_number,
    input  logic [mva_pkg::VEL_W-1:0]       i_note_velocity,
    output logic                            o_done,
    output logic                            o_status,
    output logic                            o_action_valid,
    output logic [mva_pkg::VOICE_IDX_W-1:0] o_voice_index,
    output logic [mva_pkg::NOTE_W-1:0]      o_action_note,
    output logic [mva_pkg::VEL_W-1:0]       o_action_velocity,
    output logic                            o_action_on,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mva_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mva_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mva_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status dp_status;
    logic       ctrl_busy;

    assign busy        = ctrl_busy;
    // a command transfer in the same cycle takes precedence over a register write
    assign o_cfg_ready = !ctrl_busy && !start;

    mva_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (dp_status),
        .o_cmd    (cmd),
        .busy     (ctrl_busy)
    );

    mva_datapath #(
        .MAX_VOICES (MAX_VOICES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status_bits     (dp_status),
        .i_cfg_write       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_opcode          (i_opcode),
        .i_command         (i_command),
        .i_note_number     (i_note_number),
        .i_note_velocity   (i_note_velocity),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_action_valid    (o_action_valid),
        .o_voice_index     (o_voice_index),
        .o_action_note     (o_action_note),
        .o_action_velocity (o_action_velocity),
        .o_action_on       (o_action_on)
    );

endmodule

// ===== hdl/mva_checker.sv =====
module mva_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic       o_status,
    input logic       o_action_valid,
    input logic [3:0] o_voice_index,
    input logic [6:0] o_action_note,
    input logic [6:0] o_action_velocity,
    input logic       o_action_on
);

    // an accepted message always makes the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted start");

    // result appears only as the block goes idle
    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("result strobe outside end of processing");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_no_action_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_action_valid) |->
            (o_voice_index == 4'd0 && o_action_note == 7'd0 &&
             o_action_velocity == 7'd0 && !o_action_on))
        else $error("action fields nonzero without action");

    a_action_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_action_valid) |-> !o_status)
        else $error("action reported with bad status");

endmodule

bind midi_voice_allocator mva_checker u_mva_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_status          (o_status),
    .o_action_valid    (o_action_valid),
    .o_voice_index     (o_voice_index),
    .o_action_note     (o_action_note),
    .o_action_velocity (o_action_velocity),
    .o_action_on       (o_action_on)
);
